@@ rtl/byte_packet_deframer_macros.svh @@
// Assertion macros shared by the deframer checker.
`ifndef BYTE_PACKET_DEFRAMER_MACROS_SVH
`define BYTE_PACKET_DEFRAMER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define BPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define BPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bpd_pkg.sv @@
package bpd_pkg;

  // Default frame length limit, delimiters included.
  localparam int MAX_FRAME_LEN_DEF = 50;

  // Reset values of the delimiter registers.
  localparam logic [7:0] START_RESET = 8'd171;
  localparam logic [7:0] END_RESET   = 8'd187;

  // Configuration register indexes.
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // accept the input item this cycle
    logic rd_clear;    // restart the drain at entry zero
    logic rd_inc;      // step the drain to the next entry
    logic load_byte;   // load the output register from the store
    logic load_empty;  // load the output register with the empty result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_done;  // the current input byte closes a frame
    logic frame_empty; // the closed frame has no payload
    logic rd_at_last;  // the drain points at the final payload entry
    logic out_free;    // the output register can take a new item
  } status_t;

endpackage

@@ rtl/bpd_datapath.sv @@
module bpd_datapath #(
  parameter int MAX_FRAME_LEN = bpd_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic [7:0]      rx_byte,
  input  logic            out_stall,
  input  bpd_pkg::cmd_t   cmd,
  output bpd_pkg::status_t stat,
  output logic            out_valid,
  output logic [7:0]      payload_byte,
  output logic            is_last,
  output logic            is_empty
);

  localparam int CAP = MAX_FRAME_LEN - 2;
  localparam int CW  = $clog2(CAP + 1);
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAP);

  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic          in_frame;
  logic [CW-1:0] count;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic [7:0]    mem [CAP];

  logic is_start;
  logic is_end;
  logic do_write;

  assign is_start = (rx_byte == start_byte);
  assign is_end   = (rx_byte == end_byte);
  assign do_write = cmd.take && in_frame && !is_start && !is_end && (count != CAP_CNT);

  // Status toward the controller.
  assign stat.frame_done  = in_frame && is_end;
  assign stat.frame_empty = is_start || (count == '0);
  assign stat.rd_at_last  = (rd_idx == last_idx);
  assign stat.out_free    = !out_valid || !out_stall;

  // Delimiter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= bpd_pkg::START_RESET;
      end_byte   <= bpd_pkg::END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bpd_pkg::CFG_START: start_byte <= cfg_data;
        bpd_pkg::CFG_END:   end_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state: hunting, collecting, restart, close and overflow drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      count    <= '0;
    end else if (cmd.take) begin
      if (!in_frame) begin
        if (is_start) begin
          in_frame <= 1'b1;
          count    <= '0;
        end
      end else if (is_start) begin
        count <= '0;
        if (is_end) begin
          in_frame <= 1'b0;
        end
      end else if (is_end) begin
        count    <= '0;
        in_frame <= 1'b0;
      end else if (count == CAP_CNT) begin
        count    <= '0;
        in_frame <= 1'b0;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // Index of the final payload byte, kept for the drain.
  always_ff @(posedge clk) begin
    if (cmd.take && stat.frame_done) begin
      last_idx <= AW'(count - CW'(1));
    end
  end

  // Payload store with a registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count[AW-1:0]] <= rx_byte;
    end
    rd_data <= mem[rd_idx];
  end

  // Drain pointer.
  always_ff @(posedge clk) begin
    if (cmd.rd_clear) begin
      rd_idx <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_byte || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      payload_byte <= rd_data;
      is_last      <= stat.rd_at_last;
      is_empty     <= 1'b0;
    end else if (cmd.load_empty) begin
      payload_byte <= 8'd0;
      is_last      <= 1'b1;
      is_empty     <= 1'b1;
    end
  end

endmodule

@@ rtl/bpd_controller.sv @@
module bpd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  bpd_pkg::status_t stat,
  output logic             in_stall,
  output bpd_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'b0001,
    ST_READ   = 4'b0010,
    ST_LOAD   = 4'b0100,
    ST_EMPTY  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_ACCEPT);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_ACCEPT: begin
        cmd.take = in_valid;
        if (in_valid && stat.frame_done) begin
          if (stat.frame_empty) begin
            state_next = ST_EMPTY;
          end else begin
            cmd.rd_clear = 1'b1;
            state_next   = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          if (stat.rd_at_last) begin
            state_next = ST_ACCEPT;
          end else begin
            cmd.rd_inc = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = ST_ACCEPT;
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/byte_packet_deframer.sv @@
// Input bytes are taken one per cycle while no frame is draining.
// A closing byte starts the drain: each payload byte takes a store read, then an output
// load, and an empty frame takes only the empty-result load; the input stays held
// until the last of these is loaded, and result-side stalls hold it longer.
// Reset (synchronous, active high) restores the delimiter defaults, resumes
// hunting and clears the output; the payload store is not cleared.
module byte_packet_deframer #(
  parameter int MAX_FRAME_LEN = bpd_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       is_last,
  output logic       is_empty
);

  bpd_pkg::cmd_t    cmd;
  bpd_pkg::status_t stat;

  // Sequencer.
  bpd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Frame state, payload store and output register.
  bpd_datapath #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .payload_byte (payload_byte),
    .is_last      (is_last),
    .is_empty     (is_empty)
  );

endmodule

@@ rtl/bpd_checker.sv @@
`include "byte_packet_deframer_macros.svh"

module bpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] payload_byte,
  input logic       is_last,
  input logic       is_empty
);

  logic       out_held;
  logic [9:0] out_word;

  // A result item that waits on a stall, and its whole payload.
  assign out_held = out_valid && out_stall;
  assign out_word = {payload_byte, is_last, is_empty};

  // A stalled result item stays valid and unchanged.
  `BPD_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_word), "stalled item changed")

  // No result item is shown in the cycle after reset.
  `BPD_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

  // The empty result is always the last of its frame.
  `BPD_ASSERT(a_empty_last, out_valid && is_empty |-> is_last, "empty result not marked last")

  // The empty result carries a zero byte.
  `BPD_ASSERT(a_empty_zero, out_valid && is_empty |-> payload_byte == 8'd0, "empty byte not zero")

endmodule

bind byte_packet_deframer bpd_checker u_bpd_checker (.*);

@@ dv/byte_packet_deframer_check.sv @@
// Watches the configuration port and both item channels of the deframer,
// predicts the payload items of every frame and compares them as they leave.
module byte_packet_deframer_check #(
  parameter int MAX_FRAME_LEN = bpd_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] payload_byte,
  input  logic       is_last,
  input  logic       is_empty,
  output int         outstanding,
  output int         mismatch_count
);

  localparam int PAYLOAD_CAP = MAX_FRAME_LEN - 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } payload_item_t;

  // Payload items that the frames seen so far still owe.
  payload_item_t owed_payload[$];

  // Shadow copy of the delimiters and of the frame being collected.
  logic [7:0] open_byte;
  logic [7:0] close_byte;
  logic [7:0] frame_store [PAYLOAD_CAP];
  int         frame_len;
  logic       in_frame;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Queues the items of a closed frame and goes back to hunting.
  task automatic close_frame();
    payload_item_t item;
    if (frame_len == 0) begin
      item.data  = 8'd0;
      item.last  = 1'b1;
      item.empty = 1'b1;
      owed_payload.push_back(item);
    end else begin
      for (int k = 0; k < frame_len; k++) begin
        item.data  = frame_store[k];
        item.last  = (k + 1 == frame_len);
        item.empty = 1'b0;
        owed_payload.push_back(item);
      end
    end
    frame_len = 0;
    in_frame  = 1'b0;
  endtask

  // Advances the shadow frame state by one received byte.
  task automatic deframe_byte(input logic [7:0] b);
    if (!in_frame) begin
      if (b == open_byte) begin
        in_frame  = 1'b1;
        frame_len = 0;
      end
    end else if (b == open_byte) begin
      // A new opening byte restarts the frame; with equal delimiters it
      // also closes the restarted frame at once.
      frame_len = 0;
      if (b == close_byte) close_frame();
    end else if (b == close_byte) begin
      close_frame();
    end else if (frame_len + 2 >= MAX_FRAME_LEN || frame_len >= PAYLOAD_CAP) begin
      // The frame would grow past the length limit, so it is thrown away.
      frame_len = 0;
      in_frame  = 1'b0;
    end else begin
      frame_store[frame_len] = b;
      frame_len++;
    end
  endtask

  // Compares one accepted output item with the oldest owed item.
  task automatic check_payload();
    payload_item_t want;
    if (owed_payload.size() == 0) begin
      report_mismatch("unexpected item, payload_byte", 8'd0, payload_byte);
      return;
    end
    want = owed_payload.pop_front();
    if (payload_byte !== want.data) report_mismatch("payload_byte", want.data, payload_byte);
    if (is_last !== want.last) begin
      report_mismatch("is_last", {7'd0, want.last}, {7'd0, is_last});
    end
    if (is_empty !== want.empty) begin
      report_mismatch("is_empty", {7'd0, want.empty}, {7'd0, is_empty});
    end
  endtask

  initial mismatch_count = 0;

  // Samples every channel on the clock edge at which it hands over an item.
  always @(posedge clk) begin
    if (rst) begin
      open_byte  = bpd_pkg::START_RESET;
      close_byte = bpd_pkg::END_RESET;
      frame_len  = 0;
      in_frame   = 1'b0;
      owed_payload.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == bpd_pkg::CFG_START) open_byte = cfg_data;
        else if (cfg_index == bpd_pkg::CFG_END) close_byte = cfg_data;
      end
      if (out_valid && !out_stall) check_payload();
      if (in_valid && !in_stall) deframe_byte(rx_byte);
    end
    outstanding <= owed_payload.size();
  end

endmodule

@@ dv/byte_packet_deframer_test.sv @@
// Drives byte streams and delimiter settings into the deframer; the checker
// beside it predicts and compares the payload items.
module byte_packet_deframer_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 8;
  localparam int BLOCK_BYTES  = 28;
  localparam int MAX_GAP      = 20;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic       is_last;
  logic       is_empty;

  int         outstanding;
  int         mismatch_count;
  int         cycle_count;
  int         gap_pct;
  int         stall_pct;
  int         bytes_sent;
  logic [7:0] open_val;
  logic [7:0] close_val;

  byte_packet_deframer uut (.*);

  byte_packet_deframer_check monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, as often as the current phase asks.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one byte, after a random gap, and returns once it is accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops sending until every owed item has come out and the block is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Writes both delimiter registers on back-to-back cycles.
  task automatic program_delims(input logic [7:0] open_b, input logic [7:0] close_b);
    cfg_we    <= 1'b1;
    cfg_index <= bpd_pkg::CFG_START;
    cfg_data  <= open_b;
    @(posedge clk);
    cfg_index <= bpd_pkg::CFG_END;
    cfg_data  <= close_b;
    @(posedge clk);
    cfg_we    <= 1'b0;
    open_val  = open_b;
    close_val = close_b;
  endtask

  // Sends one frame with random content; now and then a payload byte is any
  // value (which may restart or close early) or the closing byte is left out.
  task automatic send_frame(input int payload_len);
    logic [7:0] b;
    send_byte(open_val);
    for (int k = 0; k < payload_len; k++) begin
      if ($urandom_range(99) < 8) begin
        b = 8'($urandom_range(255));
      end else begin
        do b = 8'($urandom_range(255)); while (b == open_val || b == close_val);
      end
      send_byte(b);
    end
    if ($urandom_range(99) < 90) send_byte(close_val);
  endtask

  initial begin
    int block_start;
    int pick;
    int len;
    logic [7:0] v;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = bpd_pkg::CFG_START;
    cfg_data   = 8'd0;
    in_valid   = 1'b0;
    rx_byte    = 8'd0;
    out_stall  = 1'b0;
    cycle_count = 0;
    bytes_sent = 0;
    gap_pct    = 31;
    stall_pct  = 70;
    open_val   = bpd_pkg::START_RESET;
    close_val  = bpd_pkg::END_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bytes dropped while hunting, an empty frame, a frame of
    // extreme values, a restart inside a frame, then a frame left open.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(close_val);
    send_byte(open_val);
    send_byte(close_val);
    send_byte(open_val);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(close_val);
    send_byte(open_val);
    send_byte(8'h11);
    send_byte(open_val);
    send_byte(8'h33);
    send_byte(close_val);
    send_byte(open_val);
    send_byte(8'h12);

    // Equal delimiters, written while the frame above is still open: the
    // shared value restarts and closes it, then opens and closes again.
    wait_idle();
    program_delims(8'h5A, 8'h5A);
    send_byte(8'h5A);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h5A);

    // Random frames under three idling patterns and four delimiter settings.
    for (int mode = 0; mode < 3; mode++) begin
      gap_pct   = (mode == 0) ? 31 : (mode == 1) ? 70 : 0;
      stall_pct = (mode == 0) ? 70 : (mode == 1) ? 31 : 0;
      for (int sel = 0; sel < 4; sel++) begin
        wait_idle();
        v = 8'($urandom_range(255));
        case (sel)
          0: program_delims(8'h00, 8'hFF);
          1: program_delims(8'hFF, 8'h00);
          2: program_delims(v, v);
          default: begin
            if (mode == 2) program_delims(bpd_pkg::START_RESET, bpd_pkg::END_RESET);
            else program_delims(v, 8'($urandom_range(255)));
          end
        endcase
        block_start = bytes_sent;
        // In the first phase, a frame at the length limit: just below, at, or over.
        if (mode == 0 && sel < 3) send_frame(47 + sel);
        while (bytes_sent - block_start < BLOCK_BYTES) begin
          if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
          end
          pick = $urandom_range(99);
          if (pick < 60) len = $urandom_range(8);
          else if (pick < 85) len = $urandom_range(9, 30);
          else len = $urandom_range(44, 52);
          send_frame(len);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
